### sv/lpe_pkg.sv
// types, codes and state encoding shared by the engine top level and its checker
`default_nettype none

package lpe_pkg;

  localparam int SYM_W  = 5;
  localparam int PROD_W = 5;
  localparam int LEN_W  = 4;
  localparam int TENT_W = PROD_W + 1;

  localparam logic [2:0] K_TABLE = 3'd0;
  localparam logic [2:0] K_SYM   = 3'd1;
  localparam logic [2:0] K_LEN   = 3'd2;
  localparam logic [2:0] K_BEGIN = 3'd3;
  localparam logic [2:0] K_TOKEN = 3'd4;

  localparam logic [2:0] ST_EXPANDED = 3'd0;
  localparam logic [2:0] ST_MATCHED  = 3'd1;
  localparam logic [2:0] ST_ACCEPTED = 3'd2;
  localparam logic [2:0] ST_SYNTAX   = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;
  localparam logic [2:0] ST_LIMIT    = 3'd5;
  localparam logic [2:0] ST_IDLE     = 3'd6;

  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_END   = 2'd1;
  localparam logic [1:0] CFG_EPS   = 2'd2;

  typedef struct packed {
    logic [2:0]        kind;
    logic [SYM_W-1:0]  table_row;
    logic [SYM_W-1:0]  table_col;
    logic [PROD_W-1:0] prod_index;
    logic [2:0]        rhs_pos;
    logic [SYM_W-1:0]  symbol;
    logic              entry_valid;
    logic [LEN_W-1:0]  rhs_length;
  } item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [PROD_W-1:0] production;
    logic [SYM_W-1:0]  error_symbol;
    logic              last;
  } result_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_BEGIN, S_POP, S_TOP, S_TBL, S_LEN, S_CNT, S_CHK, S_PUSH
  } state_t;

endpackage

`default_nettype wire

### sv/lpe_ram.sv
// generic single write port ram with registered read
`default_nettype none

module lpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/ll1_predictive_parse_engine.sv
// top level of the table driven ll(1) parse engine
//
// item channel: an item is taken when start is high and busy is low. load
// items (table, production symbol, production length) are written in the
// accept cycle and the engine stays free. a begin item seeds the stack.
// a token item while no parse runs gives one not-parsing result on the next
// cycle. otherwise the token runs a sequencer over the stack memory: a
// pop passes S_POP and S_TOP, a table lookup S_TBL, and an expansion of a
// production with n right side symbols S_LEN, S_CNT, S_CHK and S_PUSH;
// each right side symbol is read once to count pushes and once to push it.
// results: result_valid strobes for one cycle per result, last marks the
// final result of a token; the receiver cannot stall the engine.
// configuration: cfg_we writes register cfg_index at once; the user must
// write it only while idle, which the block does not enforce. reset: the
// parse table is swept to all invalid, one entry a cycle, with busy high.
`default_nettype none

module ll1_predictive_parse_engine #(
  parameter int SYMBOLS        = 32,
  parameter int PRODUCTIONS    = 32,
  parameter int MAX_RHS        = 8,
  parameter int STACK_DEPTH    = 64,
  parameter int MAX_EXPANSIONS = 15
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire lpe_pkg::item_t  item,
  output logic                 result_valid,
  output lpe_pkg::result_t     result,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [4:0]      cfg_data
);

  import lpe_pkg::*;

  localparam int TDEPTH = SYMBOLS * SYMBOLS;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int SDEPTH = PRODUCTIONS * MAX_RHS;
  localparam int SAW    = $clog2(SDEPTH);
  localparam int LAW    = $clog2(PRODUCTIONS);
  localparam int SW     = $clog2(STACK_DEPTH);
  localparam int CW     = $clog2(STACK_DEPTH + 1);
  localparam int KW     = $clog2(MAX_RHS + 1);
  localparam int EW     = $clog2(MAX_EXPANSIONS + 1);

  state_t state, state_next;

  logic [SYM_W-1:0]  start_symbol, end_marker, epsilon_symbol;
  logic [CW-1:0]     count;
  logic              active;
  logic [SYM_W-1:0]  tok, top;
  logic [PROD_W-1:0] prod;
  logic [KW-1:0]     len, k, pushes;
  logic              pend;
  logic [EW-1:0]     expansions;
  logic [TAW-1:0]    clr;

  logic              tbl_we, stk_we, sym_we, len_we;
  logic [TAW-1:0]    tbl_waddr, tbl_raddr;
  logic [TENT_W-1:0] tbl_wdata, tbl_rdata;
  logic [SW-1:0]     stk_waddr, stk_raddr;
  logic [SYM_W-1:0]  stk_wdata, stk_rdata;
  logic [SAW-1:0]    sym_waddr, sym_raddr;
  logic [SYM_W-1:0]  sym_rdata;
  logic [LAW-1:0]    len_waddr, len_raddr;
  logic [LEN_W-1:0]  len_wdata, len_rdata;

  logic              res_fire;
  result_t           res_next;
  logic              accept;
  logic [CW-1:0]     count_m1;
  logic [PROD_W-1:0] tbl_prod;
  logic              issue;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign count_m1 = count - 1'b1;
  assign tbl_prod = (32'(tbl_rdata[PROD_W-1:0]) < PRODUCTIONS) ? tbl_rdata[PROD_W-1:0] : '0;

  lpe_ram #(.WIDTH(TENT_W), .DEPTH(TDEPTH)) u_table (
    .clk, .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  lpe_ram #(.WIDTH(SYM_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  lpe_ram #(.WIDTH(SYM_W), .DEPTH(SDEPTH)) u_syms (
    .clk, .we(sym_we), .waddr(sym_waddr), .wdata(item.symbol),
    .raddr(sym_raddr), .rdata(sym_rdata)
  );

  lpe_ram #(.WIDTH(LEN_W), .DEPTH(PRODUCTIONS)) u_lens (
    .clk, .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
    .raddr(len_raddr), .rdata(len_rdata)
  );

  assign tbl_waddr = (state == S_CLEAR) ? clr
                   : TAW'(32'(item.table_row) * SYMBOLS + 32'(item.table_col));
  assign tbl_wdata = (state == S_CLEAR) ? '0 : {item.entry_valid, item.prod_index};
  assign tbl_raddr = TAW'(32'(stk_rdata) * SYMBOLS + 32'(tok));
  assign sym_waddr = SAW'(32'(item.prod_index) * MAX_RHS + 32'(item.rhs_pos));
  assign len_waddr = LAW'(item.prod_index);
  assign len_wdata = (32'(item.rhs_length) > MAX_RHS) ? LEN_W'(MAX_RHS) : item.rhs_length;
  assign len_raddr = LAW'(tbl_prod);
  assign stk_raddr = count_m1[SW-1:0];
  assign issue     = (state == S_PUSH) ? (k != '0) : (k < len);
  assign sym_raddr = (state == S_PUSH) ? SAW'(32'(prod) * MAX_RHS + 32'(k) - 1)
                                       : SAW'(32'(prod) * MAX_RHS + 32'(k));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    tbl_we     = 1'b0;
    stk_we     = 1'b0;
    sym_we     = 1'b0;
    len_we     = 1'b0;
    stk_waddr  = count[SW-1:0];
    stk_wdata  = sym_rdata;
    res_fire   = 1'b0;
    res_next   = '0;
    case (state)
      S_CLEAR: begin
        tbl_we = 1'b1;
        if (32'(clr) == TDEPTH - 1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (item.kind)
            K_TABLE: tbl_we = (32'(item.table_row) < SYMBOLS) &&
                              (32'(item.table_col) < SYMBOLS) &&
                              (32'(item.prod_index) < PRODUCTIONS);
            K_SYM:   sym_we = (32'(item.prod_index) < PRODUCTIONS) &&
                              (32'(item.rhs_pos) < MAX_RHS);
            K_LEN:   len_we = (32'(item.prod_index) < PRODUCTIONS);
            K_BEGIN: begin
              stk_we     = 1'b1;
              stk_waddr  = '0;
              stk_wdata  = end_marker;
              state_next = S_BEGIN;
            end
            K_TOKEN: begin
              if (!active) begin
                res_fire        = 1'b1;
                res_next.status = ST_IDLE;
                res_next.last   = 1'b1;
              end else begin
                state_next = S_POP;
              end
            end
            default: ;
          endcase
        end
      end
      S_BEGIN: begin
        stk_we     = 1'b1;
        stk_waddr  = SW'(1);
        stk_wdata  = start_symbol;
        state_next = S_IDLE;
      end
      S_POP: begin
        if (count == '0) begin
          res_fire        = 1'b1;
          res_next.status = ST_ACCEPTED;
          res_next.last   = 1'b1;
          state_next      = S_IDLE;
        end else begin
          state_next = S_TOP;
        end
      end
      S_TOP: begin
        if (stk_rdata == tok) begin
          res_fire        = 1'b1;
          res_next.status = (count == '0) ? ST_ACCEPTED : ST_MATCHED;
          res_next.last   = 1'b1;
          state_next      = S_IDLE;
        end else if (stk_rdata == end_marker) begin
          res_fire        = 1'b1;
          res_next.status = ST_ACCEPTED;
          res_next.last   = 1'b1;
          state_next      = S_IDLE;
        end else if (32'(stk_rdata) < SYMBOLS && 32'(tok) < SYMBOLS) begin
          state_next = S_TBL;
        end else begin
          res_fire              = 1'b1;
          res_next.status       = ST_SYNTAX;
          res_next.error_symbol = stk_rdata;
          res_next.last         = 1'b1;
          state_next            = S_IDLE;
        end
      end
      S_TBL: begin
        if (!tbl_rdata[TENT_W-1]) begin
          res_fire              = 1'b1;
          res_next.status       = ST_SYNTAX;
          res_next.error_symbol = top;
          res_next.last         = 1'b1;
          state_next            = S_IDLE;
        end else if (32'(expansions) >= MAX_EXPANSIONS) begin
          res_fire        = 1'b1;
          res_next.status = ST_LIMIT;
          res_next.last   = 1'b1;
          state_next      = S_IDLE;
        end else begin
          state_next = S_LEN;
        end
      end
      S_LEN: state_next = S_CNT;
      S_CNT: begin
        if (!issue && !pend) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (32'(count) + 32'(pushes) > STACK_DEPTH) begin
          res_fire        = 1'b1;
          res_next.status = ST_OVERFLOW;
          res_next.last   = 1'b1;
          state_next      = S_IDLE;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        stk_we = pend && (sym_rdata != epsilon_symbol);
        if (!issue && !pend) begin
          res_fire            = 1'b1;
          res_next.status     = ST_EXPANDED;
          res_next.production = prod;
          state_next          = S_POP;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_symbol   <= '0;
      end_marker     <= SYM_W'(1);
      epsilon_symbol <= SYM_W'(2);
      count          <= '0;
      active         <= 1'b0;
      clr            <= '0;
      pend           <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_START: start_symbol   <= cfg_data;
          CFG_END:   end_marker     <= cfg_data;
          CFG_EPS:   epsilon_symbol <= cfg_data;
          default: ;
        endcase
      end
      result_valid <= res_fire;
      if (res_fire && res_next.last && state != S_IDLE) begin
        active <= (res_next.status == ST_MATCHED);
      end
      case (state)
        S_CLEAR: clr <= clr + 1'b1;
        S_IDLE: begin
          tok        <= item.symbol;
          expansions <= '0;
        end
        S_BEGIN: begin
          count  <= CW'(2);
          active <= 1'b1;
        end
        S_POP:  if (count != '0) count <= count_m1;
        S_TOP:  top <= stk_rdata;
        S_TBL:  prod <= tbl_prod;
        S_LEN: begin
          len    <= KW'(len_rdata);
          k      <= '0;
          pushes <= '0;
          pend   <= 1'b0;
        end
        S_CNT: begin
          if (issue) k <= k + 1'b1;
          pend <= issue;
          if (pend && sym_rdata != epsilon_symbol) pushes <= pushes + 1'b1;
        end
        S_CHK: begin
          k    <= len;
          pend <= 1'b0;
        end
        S_PUSH: begin
          if (issue) k <= k - 1'b1;
          pend <= issue;
          if (stk_we) count <= count + 1'b1;
          if (!issue && !pend) expansions <= expansions + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      result <= res_next;
    end
  end

endmodule

`default_nettype wire

### sv/lpe_checker.sv
// port level checks on the parse engine and their binding
`default_nettype none

module lpe_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire lpe_pkg::item_t   item,
  input wire logic             result_valid,
  input wire lpe_pkg::result_t result
);

  import lpe_pkg::*;

  a_final_codes: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_EXPANDED |-> result.last)
    else $error("terminal status without last");

  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("engine free with results pending");

  a_err_sym: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_SYNTAX |-> result.error_symbol == '0)
    else $error("error symbol outside syntax error");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.kind != K_TOKEN |=> !result_valid)
    else $error("result after a load or begin item");

endmodule

bind ll1_predictive_parse_engine lpe_checker u_lpe_checker (
  .clk, .rst, .start, .busy, .item, .result_valid, .result
);

`default_nettype wire
